>>> rtl/core/cet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_pkg
// Shared types, constants and the microcode table of the cubic escape-time
// iteration block.
// ----------------------------------------------------------------------------
package cet_pkg;

  // Integer bits of the internal fixed-point format.
  localparam int INT_BITS = 12;

  // Widths of the fixed item fields.
  localparam int IN_W     = 32;
  localparam int COUNT_W  = 10;
  localparam int CFG_W    = 32;
  localparam int CFG_AW   = 3;
  localparam int PC_W     = 6;

  // Register map.
  localparam logic [CFG_AW-1:0] CFG_ADDR_MAX_ITER = 3'd0;
  localparam int                MAX_ITER_RESET    = 100;

  // Microcode landmarks.
  localparam logic [PC_W-1:0] PC_SETUP_END = 6'd16;
  localparam logic [PC_W-1:0] PC_LOOP      = 6'd17;
  localparam logic [PC_W-1:0] PC_LOOP_END  = 6'd34;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DBL,
    OP_TRP,
    OP_CPY
  } op_t;

  typedef enum logic [3:0] {
    R_ARE,
    R_AIM,
    R_A2RE,
    R_A2IM,
    R_BRE,
    R_BIM,
    R_RE,
    R_IM,
    R_RE2,
    R_IM2,
    R_T0,
    R_T1,
    R_TA,
    R_TB,
    R_NRE
  } reg_sel_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t sa;
    reg_sel_t sb;
    reg_sel_t dst;
  } ucmd_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    logic  mul_start;
    logic  cnt_inc;
    ucmd_t cmd;
  } dp_ctl_t;

  typedef struct packed {
    logic mul_done;
    logic escaped;
    logic limit;
  } dp_stat_t;

  // Microcode: setup of a^2 and b, then one iteration of the cubic map.
  function automatic ucmd_t ucode(input logic [PC_W-1:0] pc);
    ucmd_t c;
    begin
      case (pc)
        6'd0:  c = '{OP_MUL, R_ARE,  R_ARE, R_T0};
        6'd1:  c = '{OP_MUL, R_AIM,  R_AIM, R_T1};
        6'd2:  c = '{OP_SUB, R_T0,   R_T1,  R_A2RE};
        6'd3:  c = '{OP_MUL, R_ARE,  R_AIM, R_T0};
        6'd4:  c = '{OP_DBL, R_T0,   R_T0,  R_A2IM};
        6'd5:  c = '{OP_MUL, R_A2RE, R_ARE, R_T0};
        6'd6:  c = '{OP_MUL, R_A2IM, R_AIM, R_T1};
        6'd7:  c = '{OP_SUB, R_T0,   R_T1,  R_T0};
        6'd8:  c = '{OP_DBL, R_T0,   R_T0,  R_T0};
        6'd9:  c = '{OP_SUB, R_T0,   R_ARE, R_BRE};
        6'd10: c = '{OP_MUL, R_A2RE, R_AIM, R_T0};
        6'd11: c = '{OP_MUL, R_A2IM, R_ARE, R_T1};
        6'd12: c = '{OP_ADD, R_T0,   R_T1,  R_T0};
        6'd13: c = '{OP_DBL, R_T0,   R_T0,  R_T0};
        6'd14: c = '{OP_SUB, R_T0,   R_AIM, R_BIM};
        6'd15: c = '{OP_MUL, R_RE,   R_RE,  R_RE2};
        6'd16: c = '{OP_MUL, R_IM,   R_IM,  R_IM2};
        6'd17: c = '{OP_SUB, R_RE2,  R_IM2, R_T0};
        6'd18: c = '{OP_TRP, R_A2RE, R_A2RE, R_T1};
        6'd19: c = '{OP_SUB, R_T0,   R_T1,  R_TA};
        6'd20: c = '{OP_MUL, R_RE,   R_IM,  R_T0};
        6'd21: c = '{OP_DBL, R_T0,   R_T0,  R_T0};
        6'd22: c = '{OP_TRP, R_A2IM, R_A2IM, R_T1};
        6'd23: c = '{OP_SUB, R_T0,   R_T1,  R_TB};
        6'd24: c = '{OP_MUL, R_TA,   R_RE,  R_T0};
        6'd25: c = '{OP_MUL, R_TB,   R_IM,  R_T1};
        6'd26: c = '{OP_SUB, R_T0,   R_T1,  R_T0};
        6'd27: c = '{OP_ADD, R_T0,   R_BRE, R_NRE};
        6'd28: c = '{OP_MUL, R_TA,   R_IM,  R_T0};
        6'd29: c = '{OP_MUL, R_TB,   R_RE,  R_T1};
        6'd30: c = '{OP_ADD, R_T0,   R_T1,  R_T0};
        6'd31: c = '{OP_ADD, R_T0,   R_BIM, R_IM};
        6'd32: c = '{OP_CPY, R_NRE,  R_NRE, R_RE};
        6'd33: c = '{OP_MUL, R_RE,   R_RE,  R_RE2};
        6'd34: c = '{OP_MUL, R_IM,   R_IM,  R_IM2};
        default: c = '{OP_CPY, R_T0, R_T0,  R_T0};
      endcase
      return c;
    end
  endfunction

endpackage

>>> rtl/core/cet_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_in_if
// Input channel: one complex point per item.
// ----------------------------------------------------------------------------
interface cet_in_if import cet_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] a_real;
  logic signed [IN_W-1:0] a_imag;

  modport source (output valid, output a_real, output a_imag, input ready);
  modport sink   (input valid, input a_real, input a_imag, output ready);
endinterface

>>> rtl/core/cet_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_out_if
// Result channel: iteration count and bounded flag per item.
// ----------------------------------------------------------------------------
interface cet_out_if import cet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic               stayed_bounded;

  modport source (output valid, output iteration_count, output stayed_bounded,
                  input ready);
  modport sink   (input valid, input iteration_count, input stayed_bounded,
                  output ready);
endinterface

>>> rtl/core/cet_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_mul
// Multi-cycle signed fixed-point multiplier: two half-width partial products,
// then floor shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module cet_mul #(
  parameter int W = 40,
  parameter int F = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int QW = 2 * W - F;
  localparam logic [QW-1:0]  LIM_P = (QW'(1) << (W - 1)) - QW'(1);
  localparam logic [QW-1:0]  LIM_N = QW'(1) << (W - 1);
  localparam logic [2*W-1:0] RND   = ((2 * W)'(1) << F) - (2 * W)'(1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W - 1){1'b0}}};

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_RND} phase_t;

  phase_t             phase_r;
  logic               neg_r;
  logic [W-1:0]       ma_r;
  logic [W-1:0]       mb_r;
  logic [2*W-1:0]     acc_r;
  logic signed [W-1:0] p_r;
  logic               done_r;

  logic [H-1:0]       opb;
  logic [W+H-1:0]     prod;
  logic [2*W-1:0]     rnd;
  logic [QW-1:0]      q;
  logic signed [W-1:0] res;

  always_comb begin
    opb  = (phase_r == PH_LO) ? mb_r[H-1:0] : H'(mb_r[W-1:H]);
    prod = ma_r * opb;
    rnd  = acc_r + (neg_r ? RND : '0);
    q    = QW'(rnd >> F);
    if (q > (neg_r ? LIM_N : LIM_P)) begin
      res = neg_r ? VMIN : VMAX;
    end else if (neg_r) begin
      res = -W'(q);
    end else begin
      res = W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r <= PH_LO;
          end
        end
        PH_LO:   phase_r <= PH_HI;
        PH_HI:   phase_r <= PH_RND;
        PH_RND: begin
          phase_r <= PH_IDLE;
          done_r  <= 1'b1;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        neg_r <= a[W-1] ^ b[W-1];
        ma_r  <= a[W-1] ? W'(-a) : W'(a);
        mb_r  <= b[W-1] ? W'(-b) : W'(b);
      end
      PH_LO:  acc_r <= (2 * W)'(prod);
      PH_HI:  acc_r <= acc_r + ((2 * W)'(prod) << H);
      PH_RND: p_r   <= res;
      default: ;
    endcase
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

>>> rtl/core/cet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_dp
// Datapath: named fixed-point registers, a saturating add/scale unit, the
// shared multiplier, the escape test and the step counter.
// ----------------------------------------------------------------------------
module cet_dp import cet_pkg::*; #(
  parameter int W  = 40,
  parameter int F  = 28,
  parameter int CW = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [IN_W-1:0] a_real,
  input  logic signed [IN_W-1:0] a_imag,
  input  logic [CW-1:0]          max_iter,
  input  dp_ctl_t                ctl,
  output dp_stat_t               stat,
  output logic [CW-1:0]          count
);

  localparam logic signed [63:0]  VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0]  VMIN64 = -VMAX64 - 64'sd1;
  localparam logic signed [W+1:0] EMAX   = (W + 2)'(VMAX64);
  localparam logic signed [W+1:0] EMIN   = (W + 2)'(VMIN64);
  localparam logic signed [W:0]   BOUND  = (W + 1)'(10) <<< F;

  logic signed [W-1:0] are_r, aim_r, a2re_r, a2im_r, bre_r, bim_r;
  logic signed [W-1:0] re_r, im_r, re2_r, im2_r, t0_r, t1_r, ta_r, tb_r, nre_r;
  logic [CW-1:0]       cnt_r;
  reg_sel_t            mdst_r;

  logic signed [W-1:0] op_a, op_b, alu, wdata, mul_p, ld_re, ld_im;
  logic signed [W+1:0] ea, eb, sum;
  logic signed [W:0]   mag;
  logic                mul_done, wen;
  reg_sel_t            wsel;

  function automatic logic signed [W-1:0] sat_in(input logic signed [IN_W-1:0] v);
    logic signed [63:0] x;
    begin
      x = 64'(v);
      if (x > VMAX64) begin
        return W'(VMAX64);
      end else if (x < VMIN64) begin
        return W'(VMIN64);
      end
      return W'(x);
    end
  endfunction

  always_comb begin
    case (ctl.cmd.sa)
      R_ARE:   op_a = are_r;
      R_AIM:   op_a = aim_r;
      R_A2RE:  op_a = a2re_r;
      R_A2IM:  op_a = a2im_r;
      R_BRE:   op_a = bre_r;
      R_BIM:   op_a = bim_r;
      R_RE:    op_a = re_r;
      R_IM:    op_a = im_r;
      R_RE2:   op_a = re2_r;
      R_IM2:   op_a = im2_r;
      R_T0:    op_a = t0_r;
      R_T1:    op_a = t1_r;
      R_TA:    op_a = ta_r;
      R_TB:    op_a = tb_r;
      R_NRE:   op_a = nre_r;
      default: op_a = '0;
    endcase
    case (ctl.cmd.sb)
      R_ARE:   op_b = are_r;
      R_AIM:   op_b = aim_r;
      R_A2RE:  op_b = a2re_r;
      R_A2IM:  op_b = a2im_r;
      R_BRE:   op_b = bre_r;
      R_BIM:   op_b = bim_r;
      R_RE:    op_b = re_r;
      R_IM:    op_b = im_r;
      R_RE2:   op_b = re2_r;
      R_IM2:   op_b = im2_r;
      R_T0:    op_b = t0_r;
      R_T1:    op_b = t1_r;
      R_TA:    op_b = ta_r;
      R_TB:    op_b = tb_r;
      R_NRE:   op_b = nre_r;
      default: op_b = '0;
    endcase
  end

  // Saturating add, subtract, doubling and tripling.
  always_comb begin
    ea = (W + 2)'(op_a);
    eb = (W + 2)'(op_b);
    case (ctl.cmd.op)
      OP_ADD:  sum = ea + eb;
      OP_SUB:  sum = ea - eb;
      OP_DBL:  sum = ea + ea;
      OP_TRP:  sum = ea + ea + ea;
      default: sum = ea;
    endcase
    if (sum > EMAX) begin
      alu = W'(VMAX64);
    end else if (sum < EMIN) begin
      alu = W'(VMIN64);
    end else begin
      alu = W'(sum);
    end
  end

  cet_mul #(.W(W), .F(F)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    wen   = ctl.exec | mul_done;
    wsel  = mul_done ? mdst_r : ctl.cmd.dst;
    wdata = mul_done ? mul_p : alu;
    ld_re = sat_in(a_real);
    ld_im = sat_in(a_imag);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_start) begin
      mdst_r <= ctl.cmd.dst;
    end
    if (ctl.load) begin
      are_r <= ld_re;
      aim_r <= ld_im;
      re_r  <= ld_re;
      im_r  <= ld_im;
      cnt_r <= '0;
    end else begin
      if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (wen) begin
        case (wsel)
          R_ARE:   are_r  <= wdata;
          R_AIM:   aim_r  <= wdata;
          R_A2RE:  a2re_r <= wdata;
          R_A2IM:  a2im_r <= wdata;
          R_BRE:   bre_r  <= wdata;
          R_BIM:   bim_r  <= wdata;
          R_RE:    re_r   <= wdata;
          R_IM:    im_r   <= wdata;
          R_RE2:   re2_r  <= wdata;
          R_IM2:   im2_r  <= wdata;
          R_T0:    t0_r   <= wdata;
          R_T1:    t1_r   <= wdata;
          R_TA:    ta_r   <= wdata;
          R_TB:    tb_r   <= wdata;
          R_NRE:   nre_r  <= wdata;
          default: ;
        endcase
      end
    end
  end

  // Both squares are non-negative, so the sum never reaches saturation
  // below the bound and an exact compare is enough.
  assign mag           = (W + 1)'(re2_r) + (W + 1)'(im2_r);
  assign stat.escaped  = (mag >= BOUND);
  assign stat.limit    = (cnt_r >= max_iter);
  assign stat.mul_done = mul_done;
  assign count         = cnt_r;

endmodule

>>> rtl/core/cet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_ctrl
// Controller: steps the microcode, waits on the multiplier, runs the escape
// test between iterations and hands the result to the output register.
// ----------------------------------------------------------------------------
module cet_ctrl import cet_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  output logic     out_load,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MULW, S_TEST, S_OUT} state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucmd_t           cmd;
  logic            advance;

  always_comb begin
    cmd       = ucode(pc_r);
    ctl       = '0;
    ctl.cmd   = cmd;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    advance   = 1'b0;
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
        if (in_valid) begin
          pc_nxt    = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.op == OP_MUL) begin
          ctl.mul_start = 1'b1;
          state_nxt     = S_MULW;
        end else begin
          ctl.exec = 1'b1;
          advance  = 1'b1;
        end
      end
      S_MULW: begin
        advance     = stat.mul_done;
        ctl.cnt_inc = stat.mul_done && (pc_r == PC_LOOP_END);
      end
      S_TEST: begin
        if (stat.limit || stat.escaped) begin
          state_nxt = S_OUT;
        end else begin
          pc_nxt    = PC_LOOP;
          state_nxt = S_EXEC;
        end
      end
      S_OUT: begin
        out_load = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (advance) begin
      if (pc_r == PC_SETUP_END || pc_r == PC_LOOP_END) begin
        state_nxt = S_TEST;
      end else begin
        pc_nxt    = pc_r + PC_W'(1);
        state_nxt = S_EXEC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

>>> rtl/core/cubic_escape_time_iteration.sv
`timescale 1ns / 1ps
// The block works on one item at a time: it takes no new point until the
// previous result has been handed to the output register. Every multiply runs
// on the single shared multiplier. Reset (rst_n low, synchronous) returns
// the controller to idle, empties the output register and sets the limit to 100.
// ----------------------------------------------------------------------------
// cubic_escape_time_iteration
// Escape-time iteration of z <- z^3 - 3a^2 z + b in signed fixed point, with
// an APB-style register for the iteration limit.
// ----------------------------------------------------------------------------
module cubic_escape_time_iteration import cet_pkg::*; #(
  parameter int COUNT_WIDTH   = 10,
  parameter int FRACTION_BITS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  cet_in_if.sink            in_ch,
  cet_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]  cfg_pwdata,
  output logic [CFG_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  // Internal values carry twelve integer bits over the fraction.
  localparam int W = FRACTION_BITS + INT_BITS;

  logic [COUNT_WIDTH-1:0] max_iter_r;
  logic                   out_valid_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_stayed_r;

  dp_ctl_t                ctl;
  dp_stat_t               stat;
  logic [COUNT_WIDTH-1:0] count;
  logic                   out_free;
  logic                   out_load;
  logic                   cfg_wr;

  // The limit register. Only the low ten bits of a write are meaningful, and
  // the stored value is kept to the counter width.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr == CFG_ADDR_MAX_ITER);
  assign cfg_prdata = CFG_W'(max_iter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= COUNT_WIDTH'(MAX_ITER_RESET);
    end else if (cfg_wr) begin
      max_iter_r <= COUNT_WIDTH'(cfg_pwdata[COUNT_W-1:0]);
    end
  end

  // The controller sequences the microcode; the datapath holds the values.
  cet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .out_load (out_load),
    .stat     (stat),
    .ctl      (ctl)
  );

  cet_dp #(.W(W), .F(FRACTION_BITS), .CW(COUNT_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .a_real   (in_ch.a_real),
    .a_imag   (in_ch.a_imag),
    .max_iter (max_iter_r),
    .ctl      (ctl),
    .stat     (stat),
    .count    (count)
  );

  // Output register. It frees the controller to take the next item while the
  // finished result waits for the sink. The bounded flag is the limit status:
  // the count stops either at the limit or on escape, and the limit wins.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r  <= COUNT_W'(count);
      out_stayed_r <= stat.limit;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.iteration_count = out_count_r;
  assign out_ch.stayed_bounded  = out_stayed_r;

endmodule

>>> rtl/core/cet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_props
// Port-level checks of the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module cet_props import cet_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_count,
  input logic               out_stayed
);

  // Only one item is in flight, so an accept closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_stayed))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result appears together with the input reopening.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the input is still closed");

endmodule

bind cubic_escape_time_iteration cet_props u_cet_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_count  (out_ch.iteration_count),
  .out_stayed (out_ch.stayed_bounded)
);

>>> dv/cet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cet_checker
// Watches the point and result channels and the register port, predicts
// the escape count of every accepted point and compares the results in order.
// ----------------------------------------------------------------------------
module cet_checker import cet_pkg::*; #(
  parameter int COUNT_WIDTH   = 10,
  parameter int FRACTION_BITS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  cet_in_if                 in_ch,
  cet_out_if                out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]  cfg_pwdata,
  output int                fail_count,
  output int                pending
);

  localparam longint VAL_MAX = (64'sd1 <<< (FRACTION_BITS + INT_BITS - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               bounded;
  } escape_t;

  escape_t            escapes_due[$];
  logic [COUNT_W-1:0] iter_limit;

  function automatic longint clamp(input logic signed [127:0] v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return longint'(v);
  endfunction

  // Full product, floored by the fraction shift, then saturated.
  function automatic longint fx_mul(input longint x, input longint y);
    logic signed [127:0] px;
    logic signed [127:0] py;
    px = x;
    py = y;
    return clamp((px * py) >>> FRACTION_BITS);
  endfunction

  function automatic longint fx_add(input longint x, input longint y);
    logic signed [127:0] px;
    px = x;
    return clamp(px + y);
  endfunction

  function automatic longint fx_sub(input longint x, input longint y);
    logic signed [127:0] px;
    px = x;
    return clamp(px - y);
  endfunction

  function automatic longint fx_scale(input longint k, input longint x);
    logic signed [127:0] px;
    px = x;
    return clamp(px * k);
  endfunction

  function automatic escape_t escape_of(input logic signed [IN_W-1:0] ar,
                                        input logic signed [IN_W-1:0] ai,
                                        input logic [COUNT_W-1:0] lim);
    longint  are, aim, a2re, a2im, bre, bim, re, im, re2, im2, t1, t2, nre;
    longint  bound;
    int      n;
    escape_t r;
    are   = clamp(ar);
    aim   = clamp(ai);
    bound = longint'(10) <<< FRACTION_BITS;
    a2re  = fx_sub(fx_mul(are, are), fx_mul(aim, aim));
    a2im  = fx_scale(2, fx_mul(are, aim));
    bre   = fx_sub(fx_scale(2, fx_sub(fx_mul(a2re, are), fx_mul(a2im, aim))), are);
    bim   = fx_sub(fx_scale(2, fx_add(fx_mul(a2re, aim), fx_mul(a2im, are))), aim);
    re    = are;
    im    = aim;
    re2   = fx_mul(re, re);
    im2   = fx_mul(im, im);
    n     = 0;
    while (n < lim && fx_add(re2, im2) < bound) begin
      t1  = fx_sub(fx_sub(re2, im2), fx_scale(3, a2re));
      t2  = fx_sub(fx_scale(2, fx_mul(re, im)), fx_scale(3, a2im));
      nre = fx_add(fx_sub(fx_mul(t1, re), fx_mul(t2, im)), bre);
      im  = fx_add(fx_add(fx_mul(t1, im), fx_mul(t2, re)), bim);
      re  = nre;
      re2 = fx_mul(re, re);
      im2 = fx_mul(im, im);
      n++;
    end
    r.count   = COUNT_W'(n);
    r.bounded = (n >= lim);
    return r;
  endfunction

  always @(posedge clk) begin
    escape_t want;
    if (!rst_n) begin
      iter_limit = COUNT_W'(MAX_ITER_RESET);
      escapes_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == CFG_ADDR_MAX_ITER)
        iter_limit = COUNT_W'(cfg_pwdata[COUNT_W-1:0] & COUNT_W'((1 << COUNT_WIDTH) - 1));
      if (in_ch.valid && in_ch.ready)
        escapes_due.push_back(escape_of(in_ch.a_real, in_ch.a_imag, iter_limit));
      if (out_ch.valid && out_ch.ready) begin
        if (escapes_due.size() == 0) begin
          $error("result with no point outstanding: count %0d bounded %0b",
                 out_ch.iteration_count, out_ch.stayed_bounded);
          fail_count++;
        end else begin
          want = escapes_due.pop_front();
          if (out_ch.iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, actual %0d",
                   want.count, out_ch.iteration_count);
            fail_count++;
          end
          if (out_ch.stayed_bounded !== want.bounded) begin
            $error("stayed_bounded: expected %0b, actual %0b",
                   want.bounded, out_ch.stayed_bounded);
            fail_count++;
          end
        end
      end
    end
    pending = escapes_due.size();
  end

endmodule

>>> dv/cubic_escape_time_iteration_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_escape_time_iteration_tb
// Feeds points to the escape-time block under several iteration limits, with
// bursty input and a stalling result side; a checker predicts every result.
// ----------------------------------------------------------------------------
module cubic_escape_time_iteration_tb;
  import cet_pkg::*;

  localparam int COUNT_WIDTH   = 10;
  localparam int FRACTION_BITS = 28;
  // The longest correct silence is one point at the top limit plus a stall;
  // this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 250000;
  // One fixed-point unit and a near-origin window where points tend to stay.
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
  localparam int unsigned NEAR = 32'h1800_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_W-1:0]  cfg_pwdata = '0;
  logic [CFG_W-1:0]  cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_age = 0;

  cet_in_if  in_ch ();
  cet_out_if out_ch ();

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.a_real = '0;
    in_ch.a_imag = '0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  cubic_escape_time_iteration #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  cet_checker #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_pready (cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The result side cycles through three behaviors: always ready, a coin
  // toss every cycle, and long stalls with the odd ready cycle. Each behavior
  // lasts a random stretch so stalls land on every phase of the block's work.
  always @(negedge clk) begin
    if (stall_age == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_age  = $urandom_range(50, 600);
    end
    stall_age--;
    case (stall_mode)
      0: begin
        out_ch.ready = 1'b1;
      end
      1: begin
        out_ch.ready = 1'($urandom_range(0, 1));
      end
      default: begin
        out_ch.ready = ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  // Watchdog: any accepted item on either channel resets the silence count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cubic_escape_time_iteration: mismatch");
      $finish;
    end
  end

  // Register write with a setup phase, then an access phase. The register takes the
  // value at the rising edge inside the access cycle.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Points arrive in bursts. Between bursts valid drops for a random gap;
  // inside a burst valid stays high and only the payload changes.
  task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid  = 1'b1;
    in_ch.a_real = re;
    in_ch.a_imag = im;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Let every outstanding result drain, with valid low, before touching the
  // register; a result in hand means the block is back to idle.
  task automatic drain();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 2 * NEAR)) - $signed(NEAR);
  endfunction

  task automatic random_phase(input int unsigned lim, input int count);
    drain();
    write_reg(CFG_ADDR_MAX_ITER, lim);
    for (int k = 0; k < count; k++) begin
      // Mostly points near the origin, where the iteration actually runs;
      // the rest spans every bit of both coordinates.
      if ($urandom_range(0, 9) < 6)
        send_point(near_coord(), near_coord());
      else
        send_point($urandom, $urandom);
      // Once per phase, hold off until the block has delivered everything.
      if (k == count / 2) drain();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed points at the reset limit of 100.
    send_point(32'sd0, 32'sd0);                        // origin stays bounded
    send_point(ONE, 32'sd0);
    send_point(-ONE, 32'sd0);
    send_point(32'sd0, ONE >>> 1);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);        // escapes at the start
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sd0);
    send_point(32'sd848000000, 32'sd0);                // just under |a|^2 = 10
    send_point(32'sd849000000, 32'sd0);                // just over it
    send_point(32'sd0, -32'sd849000000);
    send_point(32'sh1234_5678, -32'sh0765_4321);
    send_point(-32'sh0400_0000, 32'sh0C00_0000);

    // A limit of zero takes no step at all.
    drain();
    write_reg(CFG_ADDR_MAX_ITER, 0);
    send_point(32'sd0, 32'sd0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(ONE, -ONE);

    // A write to an unmapped address must leave the limit untouched.
    drain();
    write_reg(CFG_AW'(4), 32'd5);
    send_point(32'sd0, 32'sd0);

    // Top limit; the bits above the register are written as ones.
    drain();
    write_reg(CFG_ADDR_MAX_ITER, 32'hFFFF_FFFF);
    send_point(32'sd0, 32'sd0);
    send_point(32'sh0100_0000, -32'sh0080_0000);
    send_point(32'sh7FFF_FFFF, 32'sd0);
    send_point(near_coord(), near_coord());

    random_phase(20, 240);
    random_phase(1, 240);
    random_phase(7, 240);
    random_phase(33, 230);
    random_phase(12, 240);
    random_phase(3, 240);

    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("cubic_escape_time_iteration: match");
    else
      $display("cubic_escape_time_iteration: mismatch");
    $finish;
  end

endmodule
